/* hw/rtl/rpcc_pkg.sv */
// Rotary phone call controller: shared constants, register map and word types.
// No dependencies; used by rotary_phone_call_controller_core.
package rpcc_pkg;

    // phone states
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_PICKED  = 3'd1;
    localparam logic [2:0] MODE_DIALING = 3'd2;
    localparam logic [2:0] MODE_ESTAB   = 3'd3;
    localparam logic [2:0] MODE_RINGING = 3'd4;

    // command kinds
    localparam logic [1:0] CMD_STATUS = 2'd0;
    localparam logic [1:0] CMD_KEY    = 2'd1;
    localparam logic [1:0] CMD_PWR    = 2'd2;

    // key codes
    localparam logic [3:0] KEY_NONE   = 4'd0;
    localparam logic [3:0] KEY_ACCEPT = 4'd10;
    localparam logic [3:0] KEY_CLEAR  = 4'd11;

    // register map (word index = paddr[4:2])
    localparam int unsigned PADDR_W = 5;
    localparam logic [2:0] REG_DIGIT_GAP   = 3'd0;
    localparam logic [2:0] REG_CONNECT_GAP = 3'd1;
    localparam logic [2:0] REG_RING_GAP    = 3'd2;
    localparam logic [2:0] REG_BELL_PERIOD = 3'd3;
    localparam logic [2:0] REG_BELL_OFF    = 3'd4;
    localparam logic [2:0] REG_SHORT_PRESS = 3'd5;
    localparam logic [2:0] REG_LONG_PRESS  = 3'd6;

    // register reset values
    localparam logic [7:0] RST_DIGIT_GAP   = 8'd10;
    localparam logic [7:0] RST_CONNECT_GAP = 8'd200;
    localparam logic [7:0] RST_RING_GAP    = 8'd100;
    localparam logic [7:0] RST_BELL_PERIOD = 8'd20;
    localparam logic [7:0] RST_BELL_OFF    = 8'd10;
    localparam logic [7:0] RST_SHORT_PRESS = 8'd30;
    localparam logic [7:0] RST_LONG_PRESS  = 8'd255;

    localparam int unsigned MAX_RES = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] key;
        logic [7:0] ptime;
    } cmd_t;

    typedef struct packed {
        logic       tone;
        logic       bell;
        logic       lamp;
        logic [2:0] mode;
    } status_t;

    // remainder by ten through a reciprocal; exact for all 8-bit values
    function automatic logic [3:0] mod10(input logic [7:0] x);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  q10;
        logic [7:0]  r;
        begin
            prod = {8'd0, x} * 16'd205;
            q    = prod[15:11];
            q10  = {q, 3'b000} + {2'b00, q, 1'b0};
            r    = x - q10;
            return r[3:0];
        end
    endfunction

endpackage

/* hw/rtl/rotary_phone_call_controller.sv */
// Rotary phone call controller core: tick decode, phone state machine and result queue.
// Depends on rpcc_pkg (hw/rtl/rpcc_pkg.sv).
//
// Use:
//   Input channel (in_valid/in_ready): one word per 25 ms tick carrying the sampled
//   on_hook, dial_contact and ring_sense levels.
//   Output channel (out_valid/out_ready): one to three result words per tick, each a
//   command (status only, key press or power press) with key code and press time,
//   plus the status (dial tone, bell, lamp, call state) at the end of the tick.
//   last_result marks the final word of a tick.
//   Configuration: APB-style write/read port, seven 8-bit registers at 4*i.
// Timing:
//   A tick is decoded in the cycle it is accepted; its result words are registered
//   in the result queue and then pass one by one through the output register. Results
//   leave at one word per cycle while out_ready is high; a new tick is taken while
//   the last word of the previous one moves to the output register. The result
//   queue sets this rate. After a write to bell_period the bell cadence remainder is
//   recomputed by a bit-serial divider, and in_ready is low while it runs.
// Reset and stalls:
//   rst_n clears the phone state and restores the register defaults. While
//   out_ready is low the output word holds and in_ready drops once the queue is full.
module rotary_phone_call_controller_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // tick input
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        on_hook,
    input  logic                        dial_contact,
    input  logic                        ring_sense,
    // results
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  command,
    output logic [3:0]                  key_code,
    output logic [7:0]                  press_time,
    output logic                        dialtone_on,
    output logic                        bell_on,
    output logic                        led_on,
    output logic [2:0]                  call_state,
    output logic                        last_result,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rpcc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // ---------------- configuration registers ----------------
    logic [7:0] digit_gap_reg, connect_gap_reg, ring_gap_reg;
    logic [7:0] bell_period_reg, bell_off_reg, short_press_reg, long_press_reg;
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_gap_reg   <= rpcc_pkg::RST_DIGIT_GAP;
            connect_gap_reg <= rpcc_pkg::RST_CONNECT_GAP;
            ring_gap_reg    <= rpcc_pkg::RST_RING_GAP;
            bell_period_reg <= rpcc_pkg::RST_BELL_PERIOD;
            bell_off_reg    <= rpcc_pkg::RST_BELL_OFF;
            short_press_reg <= rpcc_pkg::RST_SHORT_PRESS;
            long_press_reg  <= rpcc_pkg::RST_LONG_PRESS;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                rpcc_pkg::REG_DIGIT_GAP:   digit_gap_reg   <= pwdata[7:0];
                rpcc_pkg::REG_CONNECT_GAP: connect_gap_reg <= pwdata[7:0];
                rpcc_pkg::REG_RING_GAP:    ring_gap_reg    <= pwdata[7:0];
                rpcc_pkg::REG_BELL_PERIOD: bell_period_reg <= pwdata[7:0];
                rpcc_pkg::REG_BELL_OFF:    bell_off_reg    <= pwdata[7:0];
                rpcc_pkg::REG_SHORT_PRESS: short_press_reg <= pwdata[7:0];
                rpcc_pkg::REG_LONG_PRESS:  long_press_reg  <= pwdata[7:0];
                default: ;  // unmapped word, write ignored
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (cfg_idx)
            rpcc_pkg::REG_DIGIT_GAP:   prdata = {24'd0, digit_gap_reg};
            rpcc_pkg::REG_CONNECT_GAP: prdata = {24'd0, connect_gap_reg};
            rpcc_pkg::REG_RING_GAP:    prdata = {24'd0, ring_gap_reg};
            rpcc_pkg::REG_BELL_PERIOD: prdata = {24'd0, bell_period_reg};
            rpcc_pkg::REG_BELL_OFF:    prdata = {24'd0, bell_off_reg};
            rpcc_pkg::REG_SHORT_PRESS: prdata = {24'd0, short_press_reg};
            rpcc_pkg::REG_LONG_PRESS:  prdata = {24'd0, long_press_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // ---------------- phone state ----------------
    logic [2:0] mode_reg;
    logic       prev_hook_reg, prev_dial_reg;
    logic [7:0] pulse_count_reg, dial_idle_reg, ring_idle_reg;
    logic [7:0] bell_phase_reg;
    logic [7:0] bell_mod_reg;      // bell_phase mod bell_period, kept incrementally
    logic       tone_reg, bell_reg, lamp_reg;

    // bit-serial remainder unit, run after a bell_period write
    logic       div_busy_reg;
    logic [2:0] div_cnt_reg;
    logic [7:0] div_rem_reg;
    logic [8:0] div_trial;
    logic       div_ge;
    logic [8:0] div_diff;
    logic [7:0] div_rem_next;

    assign div_trial    = {div_rem_reg, bell_phase_reg[div_cnt_reg]};
    assign div_ge       = div_trial >= {1'b0, bell_period_reg};
    assign div_diff     = div_trial - {1'b0, bell_period_reg};
    assign div_rem_next = div_ge ? div_diff[7:0] : div_trial[7:0];

    // ---------------- result queue ----------------
    rpcc_pkg::cmd_t    pend_cmd_reg [rpcc_pkg::MAX_RES];
    rpcc_pkg::status_t pend_stat_reg;
    logic [1:0]        pend_cnt_reg;   // words still to send
    logic [1:0]        pend_idx_reg;

    logic in_acc, load_out;

    assign load_out = (pend_cnt_reg != 2'd0) && (!out_valid || out_ready);
    assign in_ready = !div_busy_reg
                      && ((pend_cnt_reg == 2'd0) || ((pend_cnt_reg == 2'd1) && load_out));
    assign in_acc   = in_valid && in_ready;

    // ---------------- tick decode ----------------
    logic [2:0]        mode_next;
    logic              prev_hook_next, prev_dial_next, tone_next, bell_next, lamp_next;
    logic [7:0]        pulse_count_next, dial_idle_next, ring_idle_next;
    logic [7:0]        bell_phase_next, bell_mod_next, cad_v;
    logic [8:0]        bm_inc;
    logic [3:0]        digit_v;
    logic [1:0]        n_v;
    rpcc_pkg::cmd_t    cmd_v [rpcc_pkg::MAX_RES];

    always_comb
    begin
        mode_next        = mode_reg;
        prev_hook_next   = prev_hook_reg;
        prev_dial_next   = prev_dial_reg;
        pulse_count_next = pulse_count_reg;
        dial_idle_next   = dial_idle_reg;
        ring_idle_next   = ring_idle_reg;
        bell_phase_next  = bell_phase_reg;
        bell_mod_next    = bell_mod_reg;
        tone_next        = tone_reg;
        bell_next        = bell_reg;
        lamp_next        = lamp_reg;
        cad_v            = 8'd0;
        bm_inc           = 9'd0;
        digit_v          = rpcc_pkg::mod10(pulse_count_reg);
        n_v              = 2'd0;
        for (int i = 0; i < rpcc_pkg::MAX_RES; i++)
        begin
            cmd_v[i] = '0;
        end

        // hook edges
        if (on_hook != prev_hook_next)
        begin
            if (on_hook)
            begin
                if (mode_next == rpcc_pkg::MODE_DIALING)
                begin
                    if (n_v != 2'd3)
                    begin
                        cmd_v[n_v] = '{rpcc_pkg::CMD_KEY, rpcc_pkg::KEY_CLEAR, long_press_reg};
                        n_v = n_v + 2'd1;
                    end
                    pulse_count_next = 8'd0;
                    dial_idle_next   = 8'd0;
                    mode_next        = rpcc_pkg::MODE_IDLE;
                end
                else if (mode_next == rpcc_pkg::MODE_ESTAB)
                begin
                    lamp_next = 1'b0;
                    if (n_v != 2'd3)
                    begin
                        cmd_v[n_v] = '{rpcc_pkg::CMD_KEY, rpcc_pkg::KEY_ACCEPT, short_press_reg};
                        n_v = n_v + 2'd1;
                    end
                    if (n_v != 2'd3)
                    begin
                        cmd_v[n_v] = '{rpcc_pkg::CMD_KEY, rpcc_pkg::KEY_CLEAR, short_press_reg};
                        n_v = n_v + 2'd1;
                    end
                    mode_next = rpcc_pkg::MODE_IDLE;
                end
                else if (mode_next != rpcc_pkg::MODE_RINGING)
                begin
                    mode_next = rpcc_pkg::MODE_IDLE;
                end
                tone_next = 1'b0;
            end
            else
            begin
                if (mode_next == rpcc_pkg::MODE_IDLE)
                begin
                    mode_next = rpcc_pkg::MODE_PICKED;
                    tone_next = 1'b1;
                end
                else if (mode_next == rpcc_pkg::MODE_RINGING)
                begin
                    bell_next = 1'b0;
                    if (n_v != 2'd3)
                    begin
                        cmd_v[n_v] = '{rpcc_pkg::CMD_KEY, rpcc_pkg::KEY_ACCEPT, short_press_reg};
                        n_v = n_v + 2'd1;
                    end
                    mode_next = rpcc_pkg::MODE_ESTAB;
                end
            end
            prev_hook_next = on_hook;
        end

        // dial pulses
        if (dial_contact != prev_dial_next)
        begin
            if (dial_contact)
            begin
                pulse_count_next = pulse_count_next + 8'd1;
                dial_idle_next   = 8'd0;
            end
            prev_dial_next = dial_contact;
        end

        // digit complete
        if ((dial_idle_next > digit_gap_reg) && (pulse_count_next != 8'd0))
        begin
            digit_v = rpcc_pkg::mod10(pulse_count_next);
            if (mode_next == rpcc_pkg::MODE_IDLE)
            begin
                if (digit_v == 4'd0)
                begin
                    // dialling zero on hook presses power
                    if (n_v != 2'd3)
                    begin
                        cmd_v[n_v] = '{rpcc_pkg::CMD_PWR, rpcc_pkg::KEY_NONE, long_press_reg};
                        n_v = n_v + 2'd1;
                    end
                    lamp_next = 1'b0;
                end
            end
            else if ((mode_next == rpcc_pkg::MODE_PICKED)
                     || (mode_next == rpcc_pkg::MODE_DIALING)
                     || (mode_next == rpcc_pkg::MODE_ESTAB))
            begin
                if (mode_next == rpcc_pkg::MODE_PICKED)
                begin
                    mode_next = rpcc_pkg::MODE_DIALING;
                    tone_next = 1'b0;
                end
                if (n_v != 2'd3)
                begin
                    cmd_v[n_v] = '{rpcc_pkg::CMD_KEY, digit_v, short_press_reg};
                    n_v = n_v + 2'd1;
                end
            end
            pulse_count_next = 8'd0;
            dial_idle_next   = 8'd0;
        end

        // long pause while dialling: connect
        if ((mode_next == rpcc_pkg::MODE_DIALING) && (dial_idle_next > connect_gap_reg))
        begin
            if (n_v != 2'd3)
            begin
                cmd_v[n_v] = '{rpcc_pkg::CMD_KEY, rpcc_pkg::KEY_ACCEPT, short_press_reg};
                n_v = n_v + 2'd1;
            end
            mode_next = rpcc_pkg::MODE_ESTAB;
            lamp_next = 1'b1;
        end

        // incoming ring and bell cadence
        if (ring_sense && (mode_next != rpcc_pkg::MODE_ESTAB))
        begin
            ring_idle_next  = 8'd0;
            mode_next       = rpcc_pkg::MODE_RINGING;
            tone_next       = 1'b0;
            lamp_next       = 1'b1;
            cad_v           = (bell_period_reg != 8'd0) ? bell_mod_next : bell_phase_next;
            bm_inc          = {1'b0, bell_mod_next} + 9'd1;
            bell_mod_next   = ((bell_phase_next == 8'hFF)
                               || (bm_inc == {1'b0, bell_period_reg}))
                              ? 8'd0 : bm_inc[7:0];
            bell_phase_next = bell_phase_next + 8'd1;
            bell_next       = !(cad_v > bell_off_reg);
        end

        // ring timeout
        if ((mode_next == rpcc_pkg::MODE_RINGING) && (ring_idle_next > ring_gap_reg))
        begin
            bell_next       = 1'b0;
            bell_phase_next = 8'd0;
            bell_mod_next   = 8'd0;
            mode_next       = prev_hook_next ? rpcc_pkg::MODE_IDLE : rpcc_pkg::MODE_PICKED;
            lamp_next       = 1'b0;
        end

        ring_idle_next = ring_idle_next + 8'd1;
        dial_idle_next = dial_idle_next + 8'd1;
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= rpcc_pkg::MODE_IDLE;
            prev_hook_reg   <= 1'b1;
            prev_dial_reg   <= 1'b1;
            pulse_count_reg <= 8'd0;
            dial_idle_reg   <= 8'd0;
            ring_idle_reg   <= 8'd0;
            bell_phase_reg  <= 8'd0;
            bell_mod_reg    <= 8'd0;
            tone_reg        <= 1'b0;
            bell_reg        <= 1'b0;
            lamp_reg        <= 1'b0;
            div_busy_reg    <= 1'b0;
            div_cnt_reg     <= 3'd0;
            div_rem_reg     <= 8'd0;
        end
        else
        begin
            if (in_acc)
            begin
                mode_reg        <= mode_next;
                prev_hook_reg   <= prev_hook_next;
                prev_dial_reg   <= prev_dial_next;
                pulse_count_reg <= pulse_count_next;
                dial_idle_reg   <= dial_idle_next;
                ring_idle_reg   <= ring_idle_next;
                bell_phase_reg  <= bell_phase_next;
                bell_mod_reg    <= bell_mod_next;
                tone_reg        <= tone_next;
                bell_reg        <= bell_next;
                lamp_reg        <= lamp_next;
            end

            // new period: recompute phase remainder, MSB first
            if (cfg_wr && (cfg_idx == rpcc_pkg::REG_BELL_PERIOD))
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= 3'd7;
                div_rem_reg  <= 8'd0;
            end
            else if (div_busy_reg)
            begin
                div_rem_reg <= div_rem_next;
                div_cnt_reg <= div_cnt_reg - 3'd1;
                if (div_cnt_reg == 3'd0)
                begin
                    div_busy_reg <= 1'b0;
                    bell_mod_reg <= div_rem_next;
                end
            end
        end
    end

    // queue fill and drain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= 2'd0;
            pend_idx_reg <= 2'd0;
        end
        else if (in_acc)
        begin
            pend_cnt_reg <= (n_v == 2'd0) ? 2'd1 : n_v;
            pend_idx_reg <= 2'd0;
        end
        else if (load_out)
        begin
            pend_cnt_reg <= pend_cnt_reg - 2'd1;
            pend_idx_reg <= pend_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int i = 0; i < rpcc_pkg::MAX_RES; i++)
            begin
                pend_cmd_reg[i] <= cmd_v[i];
            end
            pend_stat_reg <= '{tone_next, bell_next, lamp_next, mode_next};
        end
    end

    // output register
    logic out_valid_reg;
    rpcc_pkg::cmd_t    out_cmd_reg;
    rpcc_pkg::status_t out_stat_reg;
    logic out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_cmd_reg  <= pend_cmd_reg[pend_idx_reg];
            out_stat_reg <= pend_stat_reg;
            out_last_reg <= (pend_cnt_reg == 2'd1);
        end
    end

    assign out_valid   = out_valid_reg;
    assign command     = out_cmd_reg.kind;
    assign key_code    = out_cmd_reg.key;
    assign press_time  = out_cmd_reg.ptime;
    assign dialtone_on = out_stat_reg.tone;
    assign bell_on     = out_stat_reg.bell;
    assign led_on      = out_stat_reg.lamp;
    assign call_state  = out_stat_reg.mode;
    assign last_result = out_last_reg;

endmodule

/* verif/rotary_phone_call_controller_core_tb.sv */
// Self-checking testbench for rotary_phone_call_controller_core: scoreboard class,
// tick and register drivers, random idling and back-pressure on both channels.
// Depends on rpcc_pkg (hw/rtl/rpcc_pkg.sv) and the core RTL.
`timescale 1ns / 1ps

module rotary_phone_call_controller_core_tb;

    localparam int unsigned HOLD_CYCLES  = 60;    // long receiver hold-off
    localparam int unsigned STALL_LIMIT  = 3000;  // cycles with no word moving
    localparam int unsigned SETTLE_TICKS = 10;    // quiet cycles before the verdict

    // one result word as it leaves the block
    typedef struct packed {
        logic [1:0] command;
        logic [3:0] key_code;
        logic [7:0] press_time;
        logic       dialtone_on;
        logic       bell_on;
        logic       led_on;
        logic [2:0] call_state;
        logic       last_result;
    } result_word_t;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the phone machine, queues the words each tick
    // should produce and compares them against what the block emits.
    // ------------------------------------------------------------------
    class call_scoreboard;
        // register copies, at their reset values
        logic [7:0] digit_gap   = rpcc_pkg::RST_DIGIT_GAP;
        logic [7:0] connect_gap = rpcc_pkg::RST_CONNECT_GAP;
        logic [7:0] ring_gap    = rpcc_pkg::RST_RING_GAP;
        logic [7:0] bell_period = rpcc_pkg::RST_BELL_PERIOD;
        logic [7:0] bell_off    = rpcc_pkg::RST_BELL_OFF;
        logic [7:0] short_press = rpcc_pkg::RST_SHORT_PRESS;
        logic [7:0] long_press  = rpcc_pkg::RST_LONG_PRESS;

        // phone state
        logic [2:0] mode       = rpcc_pkg::MODE_IDLE;
        logic       prev_hook  = 1'b1;
        logic       prev_dial  = 1'b1;
        logic [7:0] pulses     = 8'd0;
        logic [7:0] dial_idle  = 8'd0;
        logic [7:0] ring_idle  = 8'd0;
        logic [7:0] bell_phase = 8'd0;
        logic       tone       = 1'b0;
        logic       bell       = 1'b0;
        logic       lamp       = 1'b0;

        rpcc_pkg::cmd_t tick_cmds[$];
        result_word_t   words_due[$];
        int unsigned    failures = 0;

        function void set_reg(logic [2:0] idx, logic [7:0] val);
            case (idx)
                rpcc_pkg::REG_DIGIT_GAP:   digit_gap   = val;
                rpcc_pkg::REG_CONNECT_GAP: connect_gap = val;
                rpcc_pkg::REG_RING_GAP:    ring_gap    = val;
                rpcc_pkg::REG_BELL_PERIOD: bell_period = val;
                rpcc_pkg::REG_BELL_OFF:    bell_off    = val;
                rpcc_pkg::REG_SHORT_PRESS: short_press = val;
                rpcc_pkg::REG_LONG_PRESS:  long_press  = val;
                default: ;
            endcase
        endfunction

        function void log_failure(string msg);
            failures++;
            if (failures <= 10)
                $display("ERROR @%0t: %s", $time, msg);
        endfunction

        function string show(result_word_t w);
            return $sformatf("cmd=%0d key=%0d t=%0d tone=%0b bell=%0b led=%0b st=%0d last=%0b",
                             w.command, w.key_code, w.press_time, w.dialtone_on,
                             w.bell_on, w.led_on, w.call_state, w.last_result);
        endfunction

        // at most three commands per tick, extras dropped
        function void add_cmd(logic [1:0] kind, logic [3:0] key, logic [7:0] t);
            rpcc_pkg::cmd_t c;
            c.kind  = kind;
            c.key   = key;
            c.ptime = t;
            if (tick_cmds.size() < rpcc_pkg::MAX_RES)
                tick_cmds.push_back(c);
        endfunction

        function void hang_up();
            if (mode == rpcc_pkg::MODE_DIALING)
            begin
                add_cmd(rpcc_pkg::CMD_KEY, rpcc_pkg::KEY_CLEAR, long_press);
                pulses    = 8'd0;
                dial_idle = 8'd0;
                mode      = rpcc_pkg::MODE_IDLE;
            end
            else if (mode == rpcc_pkg::MODE_ESTAB)
            begin
                lamp = 1'b0;
                add_cmd(rpcc_pkg::CMD_KEY, rpcc_pkg::KEY_ACCEPT, short_press);
                add_cmd(rpcc_pkg::CMD_KEY, rpcc_pkg::KEY_CLEAR, short_press);
                mode = rpcc_pkg::MODE_IDLE;
            end
            else if (mode != rpcc_pkg::MODE_RINGING)
            begin
                mode = rpcc_pkg::MODE_IDLE;
            end
            tone = 1'b0;
        endfunction

        function void pick_up();
            if (mode == rpcc_pkg::MODE_IDLE)
            begin
                mode = rpcc_pkg::MODE_PICKED;
                tone = 1'b1;
            end
            else if (mode == rpcc_pkg::MODE_RINGING)
            begin
                bell = 1'b0;
                add_cmd(rpcc_pkg::CMD_KEY, rpcc_pkg::KEY_ACCEPT, short_press);
                mode = rpcc_pkg::MODE_ESTAB;
            end
        endfunction

        function void digit_dialled(logic [3:0] d);
            if (mode == rpcc_pkg::MODE_IDLE)
            begin
                // a zero dialled on hook works the power button
                if (d == 4'd0)
                begin
                    add_cmd(rpcc_pkg::CMD_PWR, rpcc_pkg::KEY_NONE, long_press);
                    lamp = 1'b0;
                end
            end
            else if (mode == rpcc_pkg::MODE_PICKED || mode == rpcc_pkg::MODE_DIALING
                     || mode == rpcc_pkg::MODE_ESTAB)
            begin
                if (mode == rpcc_pkg::MODE_PICKED)
                begin
                    mode = rpcc_pkg::MODE_DIALING;
                    tone = 1'b0;
                end
                add_cmd(rpcc_pkg::CMD_KEY, d, short_press);
            end
        endfunction

        // one accepted tick: advance the machine and queue its words
        function void note_tick(logic hook, logic dial, logic ring);
            logic [7:0]   ph;
            result_word_t w;
            tick_cmds.delete();

            if (hook != prev_hook)
            begin
                if (hook)
                    hang_up();
                else
                    pick_up();
                prev_hook = hook;
            end

            if (dial != prev_dial)
            begin
                if (dial)
                begin
                    pulses    = pulses + 8'd1;
                    dial_idle = 8'd0;
                end
                prev_dial = dial;
            end

            if (dial_idle > digit_gap && pulses != 8'd0)
            begin
                digit_dialled(4'(pulses % 8'd10));
                pulses    = 8'd0;
                dial_idle = 8'd0;
            end

            if (mode == rpcc_pkg::MODE_DIALING && dial_idle > connect_gap)
            begin
                add_cmd(rpcc_pkg::CMD_KEY, rpcc_pkg::KEY_ACCEPT, short_press);
                mode = rpcc_pkg::MODE_ESTAB;
                lamp = 1'b1;
            end

            if (ring && mode != rpcc_pkg::MODE_ESTAB)
            begin
                ring_idle  = 8'd0;
                mode       = rpcc_pkg::MODE_RINGING;
                tone       = 1'b0;
                lamp       = 1'b1;
                // zero period: raw phase is compared
                ph         = (bell_period != 8'd0) ? (bell_phase % bell_period) : bell_phase;
                bell_phase = bell_phase + 8'd1;
                bell       = (ph > bell_off) ? 1'b0 : 1'b1;
            end

            if (mode == rpcc_pkg::MODE_RINGING && ring_idle > ring_gap)
            begin
                bell       = 1'b0;
                bell_phase = 8'd0;
                mode       = prev_hook ? rpcc_pkg::MODE_IDLE : rpcc_pkg::MODE_PICKED;
                lamp       = 1'b0;
            end

            ring_idle = ring_idle + 8'd1;
            dial_idle = dial_idle + 8'd1;

            if (tick_cmds.size() == 0)
                add_cmd(rpcc_pkg::CMD_STATUS, rpcc_pkg::KEY_NONE, 8'd0);

            foreach (tick_cmds[k])
            begin
                w.command     = tick_cmds[k].kind;
                w.key_code    = tick_cmds[k].key;
                w.press_time  = tick_cmds[k].ptime;
                w.dialtone_on = tone;
                w.bell_on     = bell;
                w.led_on      = lamp;
                w.call_state  = mode;
                w.last_result = (k == tick_cmds.size() - 1);
                words_due.push_back(w);
            end
        endfunction

        function void check_word(result_word_t got);
            result_word_t want;
            if (words_due.size() == 0)
            begin
                log_failure({"unexpected word: ", show(got)});
            end
            else
            begin
                want = words_due.pop_front();
                if (got.command     !== want.command     ||
                    got.key_code    !== want.key_code    ||
                    got.press_time  !== want.press_time  ||
                    got.dialtone_on !== want.dialtone_on ||
                    got.bell_on     !== want.bell_on     ||
                    got.led_on      !== want.led_on      ||
                    got.call_state  !== want.call_state  ||
                    got.last_result !== want.last_result)
                    log_failure({"word mismatch: expected ", show(want), " got ", show(got)});
            end
        endfunction

        function int unsigned pending();
            return words_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the signals driven into the block
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic                on_hook      = 1'b1;   // handset resting
    logic                dial_contact = 1'b1;   // dial contact at rest
    logic                ring_sense   = 1'b0;

    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic [1:0]          command;
    logic [3:0]          key_code;
    logic [7:0]          press_time;
    logic                dialtone_on;
    logic                bell_on;
    logic                led_on;
    logic [2:0]          call_state;
    logic                last_result;

    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [rpcc_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]         pwdata       = '0;
    logic [31:0]         prdata;
    logic                pready;

    always #5 clk = ~clk;

    rotary_phone_call_controller_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .on_hook      (on_hook),
        .dial_contact (dial_contact),
        .ring_sense   (ring_sense),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .command      (command),
        .key_code     (key_code),
        .press_time   (press_time),
        .dialtone_on  (dialtone_on),
        .bell_on      (bell_on),
        .led_on       (led_on),
        .call_state   (call_state),
        .last_result  (last_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    call_scoreboard sb = new;

    bit          calm     = 1'b0;   // both sides stop idling while set
    bit          hold_req = 1'b0;   // asks the receiver for a long hold-off
    logic        hook_lvl = 1'b1;   // current handset level for the tick sequences
    int unsigned ticks_sent = 0;
    int unsigned quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Result side: every word taken is checked against the oldest due word.
    // Sampled at the edge, so DUT outputs are their pre-edge values.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(result_word_t'({command, key_code, press_time, dialtone_on,
                                          bell_on, led_on, call_state, last_result}));
    end

    // Receiver: a random stall before each word unless calm is set, and on request a long
    // hold-off so the result queue fills and the block throttles its input.
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // Watchdog: too long without any word moving on either channel means a hang.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One tick word. Valid stays high after acceptance; the next call either
    // drops it for a gap or replaces the payload, never both in one step.
    task automatic send_tick(logic h, logic d, logic r);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        on_hook      <= h;
        dial_contact <= d;
        ring_sense   <= r;
        do @(posedge clk); while (!(in_valid && in_ready));
        sb.note_tick(h, d, r);
        ticks_sent++;
    endtask

    // Stop offering ticks and wait for every due word to arrive.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // APB write followed straight away by a read-back of the same register.
    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);              // write lands here
        sb.set_reg(idx, val);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {24'd0, val})
            sb.log_failure($sformatf("register %0d read back %0h, wrote %0h", idx, prdata, val));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_timing(logic [7:0] dg, logic [7:0] cg, logic [7:0] rg, logic [7:0] bp,
                              logic [7:0] bo, logic [7:0] sp, logic [7:0] lp);
        write_reg(rpcc_pkg::REG_DIGIT_GAP, dg);
        write_reg(rpcc_pkg::REG_CONNECT_GAP, cg);
        write_reg(rpcc_pkg::REG_RING_GAP, rg);
        write_reg(rpcc_pkg::REG_BELL_PERIOD, bp);
        write_reg(rpcc_pkg::REG_BELL_OFF, bo);
        write_reg(rpcc_pkg::REG_SHORT_PRESS, sp);
        write_reg(rpcc_pkg::REG_LONG_PRESS, lp);
    endtask

    // Short gaps keep the state machine busy; press times span the full range.
    task automatic random_timing();
        logic [7:0] dg;
        dg = 8'($urandom_range(1, 4));
        set_timing(dg, dg + 8'($urandom_range(1, 6)), 8'($urandom_range(0, 6)),
                   8'($urandom_range(1, 8)), 8'($urandom_range(0, 8)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // ticks to wait past a gap register; capped so huge gaps don't eat the run
    function automatic int unsigned gap_hold(logic [7:0] g);
        return (g > 8'd20) ? $urandom_range(1, 20) : int'(g) + $urandom_range(1, 3);
    endfunction

    task automatic hold_ticks(int unsigned n, logic r);
        repeat (n) send_tick(hook_lvl, 1'b1, r);
    endtask

    // each pulse is a contact break then make; the make counts
    task automatic pulse_train(int unsigned n);
        repeat (n)
        begin
            send_tick(hook_lvl, 1'b0, 1'b0);
            send_tick(hook_lvl, 1'b1, 1'b0);
        end
    endtask

    // hang up, let any ringing die out, lift, dial a digit and wait to connect
    task automatic establish_call();
        hook_lvl = 1'b1;
        hold_ticks(gap_hold(sb.ring_gap), 1'b0);
        hook_lvl = 1'b0;
        hold_ticks($urandom_range(1, 2), 1'b0);
        pulse_train($urandom_range(1, 10));
        hold_ticks(gap_hold(sb.digit_gap), 1'b0);
        hold_ticks(gap_hold(sb.connect_gap) + 1, 1'b0);
    endtask

    // Mostly well-formed call fragments with random content, plus some noise.
    task automatic run_scenario();
        int unsigned pick;
        pick = $urandom_range(0, 11);
        case (pick)
            0:
            begin                           // lift handset
                hook_lvl = 1'b0;
                hold_ticks($urandom_range(1, 3), 1'b0);
            end
            1, 2:
            begin                           // dial one digit, wait it out
                pulse_train($urandom_range(1, 10));
                hold_ticks(gap_hold(sb.digit_gap), 1'b0);
            end
            3: hold_ticks(gap_hold(sb.connect_gap), 1'b0);
            4:
            begin                           // hang up
                hook_lvl = 1'b1;
                hold_ticks($urandom_range(1, 3), 1'b0);
            end
            5:
            begin                           // ring burst, then let it time out
                hold_ticks($urandom_range(1, 12), 1'b1);
                hold_ticks(gap_hold(sb.ring_gap), 1'b0);
            end
            6:
            begin                           // answer an incoming call
                hold_ticks($urandom_range(1, 6), 1'b1);
                hook_lvl = ~hook_lvl;
                hold_ticks($urandom_range(1, 3), 1'($urandom_range(0, 1)));
            end
            7:
            begin
                // in a call, dial ten pulses and hang up on the tick the digit
                // comes due: accept, clear and a power press in one tick
                establish_call();
                pulse_train(10);
                hold_ticks((sb.digit_gap > 8'd20) ? 3 : int'(sb.digit_gap), 1'b0);
                hook_lvl = 1'b1;
                send_tick(1'b1, 1'b1, 1'b0);
            end
            8:
            begin                           // whole call, then hang up
                establish_call();
                pulse_train($urandom_range(1, 10));
                hold_ticks(gap_hold(sb.digit_gap), 1'b0);
                hook_lvl = 1'b1;
                hold_ticks($urandom_range(1, 3), 1'b0);
            end
            9:
            begin                           // ten pulses on hook: power press
                hook_lvl = 1'b1;
                hold_ticks(gap_hold(sb.ring_gap), 1'b0);
                pulse_train(10);
                hold_ticks(gap_hold(sb.digit_gap), 1'b0);
            end
            default:
            begin                           // noise
                repeat ($urandom_range(1, 6))
                begin
                    hook_lvl = 1'($urandom_range(0, 1));
                    send_tick(hook_lvl, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
        endcase
    endtask

    task automatic run_until(int unsigned target);
        while (ticks_sent < target) run_scenario();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        // directed ticks, {on_hook, dial_contact, ring_sense}
        logic [2:0] directed_ticks[$];
        directed_ticks = '{
            3'b010,                          // lift from idle
            3'b000, 3'b010, 3'b010,          // one pulse, digit out, dialing
            3'b010, 3'b010,                  // gap runs long: connect
            3'b110,                          // hang up in call: accept and clear
            3'b111, 3'b111, 3'b111,          // ring on hook, zero-period cadence
            3'b011, 3'b010,                  // answer the ring
            3'b110,                          // hang up in call
            3'b010, 3'b011,                  // lifted, then a ring comes in
            3'b111,                          // hang up while ringing: mode kept
            3'b110, 3'b110, 3'b110,          // ring times out on hook
            3'b010, 3'b011,                  // lifted, ring again
            3'b010, 3'b010, 3'b010,          // ring ends with handset lifted
            3'b000, 3'b010, 3'b010,          // dial a digit
            3'b110                           // hang up while dialing: clear
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: tight gaps, zero bell period, extreme press times
        set_timing(8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd255);
        foreach (directed_ticks[i])
            send_tick(directed_ticks[i][2], directed_ticks[i][1], directed_ticks[i][0]);
        hook_lvl = 1'b1;
        wait_drain();

        // random, with the receiver holding off long enough to fill the block
        random_timing();
        hold_req = 1'b1;
        run_until(110);
        wait_drain();

        // random with no idling on either side
        random_timing();
        calm = 1'b1;
        run_until(190);
        calm = 1'b0;
        wait_drain();

        // every register at its top value
        set_timing(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        run_until(230);
        wait_drain();

        // every register at its bottom value, but bell_period at 1
        set_timing(8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0);
        run_until(310);
        wait_drain();

        random_timing();
        hold_req = 1'b1;
        run_until(390);
        wait_drain();

        random_timing();
        run_until(470);
        wait_drain();

        repeat (SETTLE_TICKS) @(posedge clk);
        if (sb.pending() != 0)
            sb.log_failure($sformatf("%0d words never arrived", sb.pending()));

        if (sb.failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/rpcc_pkg.sv
hw/rtl/rotary_phone_call_controller.sv
verif/rotary_phone_call_controller_core_tb.sv
